// ===== design/hppac_pkg.sv =====
// Shared constants, types, microcode table and helper functions of the heater regulator.
package hppac_pkg;

  // Item field widths.
  localparam int ADC_BITS  = 10;
  localparam int SAMPLE_W  = 10;
  localparam int OP_W      = 2;
  localparam int SP_W      = 7;
  localparam int THR_W     = 10;
  localparam int WIN_W     = 14;
  localparam int DUTY_W    = 16;
  localparam int TEMP_W    = 15;
  localparam int VAL_W     = 16;
  localparam int DELAY_W   = 14;

  // Stream and register port widths.
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 80;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // Datapath widths.
  localparam int A_W     = 20;
  localparam int B_W     = 20;
  localparam int P_W     = A_W + B_W;
  localparam int ACC_W   = P_W + 1;
  localparam int X_W     = 19;
  localparam int SZ_W    = 18;
  localparam int SAT_W   = 24;
  localparam int STEP_W  = 5;
  localparam int UCODE_DEPTH = 2 ** STEP_W;

  // Arithmetic constants (Q16 gains, Q8.8 temperatures, Q1.15 duty).
  localparam int DUTY_FULL   = 32768;
  localparam int TEMP_SPAN   = 28160;
  localparam int K_MEAS      = 63000;
  localparam int K_DUTY      = 72286;
  localparam int K_ERR       = 9372;
  localparam int K_ERRA      = 9005;
  localparam int MEAS_SH     = 7;
  localparam int EST_SH      = 23;
  localparam int PI_SH       = 9;
  localparam int FIRE_SH     = 15;
  localparam int FILT_OLD_WT = 9;
  localparam int FILT_BIAS   = 5;
  localparam int RCP10_SH    = 22;
  localparam int RCP10       = (2 ** RCP10_SH + 9) / 10;
  localparam int RCP7_SH     = 21;
  localparam int RCP7        = (2 ** RCP7_SH + 6) / 7;
  localparam int START_SH    = 5;
  localparam int START_BIAS  = 3;
  localparam int START_X_MAX = 7 * DUTY_FULL;
  localparam int PULSE_REST_LIM = (DUTY_FULL + 9) / 10;

  // Register reset values.
  localparam logic [SP_W-1:0]  RST_SETPOINT = SP_W'(30);
  localparam logic [THR_W-1:0] RST_ZERO_THR = THR_W'(2);
  localparam logic [THR_W-1:0] RST_REARM    = THR_W'(10);
  localparam logic [WIN_W-1:0] RST_WINDOW   = WIN_W'(7333);

  // Saturation bounds for 16-bit signed results.
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** (VAL_W - 1) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

  // Item kinds and register indexes.
  typedef enum logic [OP_W-1:0] {OP_MAINS, OP_TEMP, OP_TICK, OP_START} op_e;
  typedef enum logic [1:0] {REG_SETPOINT, REG_ZERO_THR, REG_REARM_THR, REG_FIRE_WIN} reg_idx_e;

  // Control word fields.
  typedef enum logic [2:0] {
    A_MZ, A_DUTY, A_ERR, A_ERRP, A_X, A_SAMPLE, A_REST, A_TSM
  } a_sel_e;
  typedef enum logic [3:0] {
    B_MEAS, B_DUTY, B_ERR, B_ERRA, B_RCP10, B_RCP7, B_SCALE, B_NINE, B_WIN
  } b_sel_e;
  typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_LOAD_SH7, ACC_ADD, ACC_SUB} acc_op_e;
  typedef enum logic [3:0] {
    WB_NONE, WB_T, WB_SEED, WB_FILT_X, WB_FILT, WB_EST, WB_ERR, WB_DUTY_PI,
    WB_AMB, WB_START_X, WB_DUTY_DIV, WB_MAINS
  } wb_op_e;
  typedef enum logic {JMP_NEXT, JMP_RESEED} jmp_e;

  typedef struct packed {
    a_sel_e              a_sel;
    b_sel_e              b_sel;
    acc_op_e             acc_op;
    wb_op_e              wb;
    jmp_e                jmp;
    logic [STEP_W-1:0]   target;
    logic                emit;
  } ucw_t;

  // Program entry points.
  localparam logic [STEP_W-1:0] ENT_MAINS = STEP_W'(0);
  localparam logic [STEP_W-1:0] ENT_TEMP  = STEP_W'(3);
  localparam logic [STEP_W-1:0] ENT_SEED  = STEP_W'(11);
  localparam logic [STEP_W-1:0] ENT_TICK  = STEP_W'(12);
  localparam logic [STEP_W-1:0] ENT_START = STEP_W'(21);
  localparam logic [STEP_W-1:0] NO_TGT    = STEP_W'(0);

  // Microprogram. The multiplier product of one step is consumed by the
  // accumulator in the following step.
  localparam ucw_t UCODE [UCODE_DEPTH] = '{
    // Mains sample: firing delay product, then crossing logic and result.
    '{A_REST,   B_WIN,   ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 0
    '{A_REST,   B_WIN,   ACC_LOAD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 1
    '{A_REST,   B_WIN,   ACC_HOLD,     WB_MAINS,    JMP_NEXT,   NO_TGT,   1'b1}, // 2
    // Temperature sample: scale, then seed or filter.
    '{A_SAMPLE, B_SCALE, ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 3
    '{A_SAMPLE, B_SCALE, ACC_LOAD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 4
    '{A_TSM,    B_NINE,  ACC_HOLD,     WB_T,        JMP_RESEED, ENT_SEED, 1'b0}, // 5
    '{A_TSM,    B_NINE,  ACC_LOAD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 6
    '{A_X,      B_RCP10, ACC_HOLD,     WB_FILT_X,   JMP_NEXT,   NO_TGT,   1'b0}, // 7
    '{A_X,      B_RCP10, ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 8
    '{A_X,      B_RCP10, ACC_LOAD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 9
    '{A_X,      B_RCP10, ACC_HOLD,     WB_FILT,     JMP_NEXT,   NO_TGT,   1'b1}, // 10
    '{A_X,      B_RCP10, ACC_HOLD,     WB_SEED,     JMP_NEXT,   NO_TGT,   1'b1}, // 11
    // Control tick: estimate, error, incremental PI update.
    '{A_MZ,     B_MEAS,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 12
    '{A_DUTY,   B_DUTY,  ACC_LOAD_SH7, WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 13
    '{A_DUTY,   B_DUTY,  ACC_ADD,      WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 14
    '{A_DUTY,   B_DUTY,  ACC_HOLD,     WB_EST,      JMP_NEXT,   NO_TGT,   1'b0}, // 15
    '{A_DUTY,   B_DUTY,  ACC_HOLD,     WB_ERR,      JMP_NEXT,   NO_TGT,   1'b0}, // 16
    '{A_ERR,    B_ERR,   ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 17
    '{A_ERRP,   B_ERRA,  ACC_LOAD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 18
    '{A_ERRP,   B_ERRA,  ACC_SUB,      WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 19
    '{A_ERRP,   B_ERRA,  ACC_HOLD,     WB_DUTY_PI,  JMP_NEXT,   NO_TGT,   1'b1}, // 20
    // Start: capture ambient, preset duty by dividing by seven.
    '{A_X,      B_RCP7,  ACC_HOLD,     WB_AMB,      JMP_NEXT,   NO_TGT,   1'b0}, // 21
    '{A_X,      B_RCP7,  ACC_HOLD,     WB_START_X,  JMP_NEXT,   NO_TGT,   1'b0}, // 22
    '{A_X,      B_RCP7,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 23
    '{A_X,      B_RCP7,  ACC_LOAD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b0}, // 24
    '{A_X,      B_RCP7,  ACC_HOLD,     WB_DUTY_DIV, JMP_NEXT,   NO_TGT,   1'b1}, // 25
    // Unused addresses end the program at once.
    '{A_TSM,    B_NINE,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b1}, // 26
    '{A_TSM,    B_NINE,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b1}, // 27
    '{A_TSM,    B_NINE,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b1}, // 28
    '{A_TSM,    B_NINE,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b1}, // 29
    '{A_TSM,    B_NINE,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b1}, // 30
    '{A_TSM,    B_NINE,  ACC_HOLD,     WB_NONE,     JMP_NEXT,   NO_TGT,   1'b1}  // 31
  };

  // Saturate a signed value to the 16-bit signed range.
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[VAL_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[VAL_W-1:0];
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  // First microprogram step for an item kind.
  function automatic logic [STEP_W-1:0] entry_step(input op_e op);
    logic [STEP_W-1:0] s;
    unique case (op)
      OP_MAINS: s = ENT_MAINS;
      OP_TEMP:  s = ENT_TEMP;
      OP_TICK:  s = ENT_TICK;
      OP_START: s = ENT_START;
    endcase
    return s;
  endfunction

endpackage

// ===== design/heater_pi_phase_angle_controller.sv =====
// Heater regulator: microcoded sequencer with one shared multiplier, APB registers, stream I/O.
// One item is worked at a time: the input is not ready until the microprogram of the current
// item has ended, so an item occupies the block for the length of its microprogram
// (one control word per cycle, except while a result step waits for the result register,
// through a single registered 20x20 multiplier).
// The result register lets the next item be accepted while a result waits to be taken.
// Reset (rst_ni low, asynchronous) clears the regulator state, sets registers to defaults.
module heater_pi_phase_angle_controller (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input items.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [hppac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [9:0] sample
  input  logic [hppac_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // [1:0] op
  // Result items.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] fire_arm, [1] fire_now, [15:2] fire_delay_us, [16] pulse_long, [32:17] duty_out,
  // [47:33] filtered_temp, [63:48] estimated_temp, [79:64] control_error
  output logic [hppac_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Register port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hppac_pkg::ADDR_W-1:0]         paddr,
  input  logic [hppac_pkg::DATA_W-1:0]         pwdata,
  output logic [hppac_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import hppac_pkg::*;

  localparam int S_CMP_W = 17;
  localparam int ADC_MAX = 2 ** ADC_BITS - 1;

  // Sequencer control.
  logic                busy_q;
  logic [STEP_W-1:0]   step_q;
  logic                out_valid_q;
  ucw_t                cw;
  logic                out_free, step_en, exec, in_acc, cfg_wr;

  // Configuration registers.
  logic [SP_W-1:0]     sp_q;
  logic [THR_W-1:0]    zthr_q, rthr_q;
  logic [WIN_W-1:0]    win_q;

  // Regulator state.
  logic [DUTY_W-1:0]        duty_q, duty_d;
  logic signed [VAL_W-1:0]  err_q, err_d, errp_q, errp_d, est_q, est_d;
  logic [TEMP_W-1:0]        ts_q, ts_d, amb_q, amb_d;
  logic                     latch_q, latch_d, reseed_q, reseed_d;

  // Datapath.
  logic [SAMPLE_W-1:0]      sample_q, s_sat;
  logic [X_W-1:0]           x_q, x_d;
  logic signed [A_W-1:0]    a_op;
  logic signed [B_W-1:0]    b_op;
  logic signed [P_W-1:0]    p_q, p_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d, p_ext;
  logic signed [VAL_W-1:0]  mz;
  logic signed [SZ_W-1:0]   sz, err_diff;
  logic [DUTY_W:0]          rest, rest_d;
  logic [ACC_W-1:0]         est_sum, pi_sum, fire_sum;
  logic signed [SAT_W-1:0]  pi_rnd, dsum;
  logic [SAT_W-1:0]         x_full;
  logic                     crossing;

  // Result fields.
  logic                     arm_d, now_d;
  logic [DELAY_W-1:0]       delay_d;
  logic                     o_arm_q, o_now_q, o_plong_q;
  logic [DELAY_W-1:0]       o_delay_q;
  logic [DUTY_W-1:0]        o_duty_q;
  logic [TEMP_W-1:0]        o_ts_q;
  logic signed [VAL_W-1:0]  o_est_q, o_err_q;

  // Handshakes and sequencing conditions.
  assign cw            = UCODE[step_q];
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_en       = !cw.emit || out_free;
  assign exec          = busy_q && step_en;
  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && !busy_q;
  assign cfg_wr        = psel && penable && pwrite;
  assign pready        = 1'b1;

  // Register read-back.
  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_SETPOINT:  prdata = DATA_W'(sp_q);
      REG_ZERO_THR:  prdata = DATA_W'(zthr_q);
      REG_REARM_THR: prdata = DATA_W'(rthr_q);
      REG_FIRE_WIN:  prdata = DATA_W'(win_q);
    endcase
  end

  // Operand preparation.
  always_comb begin
    if ({(S_CMP_W - SAMPLE_W)'(0), sample_q} > S_CMP_W'(ADC_MAX)) begin
      s_sat = SAMPLE_W'(ADC_MAX);
    end else begin
      s_sat = sample_q;
    end
  end
  assign mz     = $signed({1'b0, ts_q}) - $signed({1'b0, amb_q});
  assign sz     = $signed({3'b0, sp_q, 8'b0}) - $signed({3'b0, amb_q});
  assign rest   = (DUTY_W + 1)'(DUTY_FULL) - {1'b0, duty_q};
  assign rest_d = (DUTY_W + 1)'(DUTY_FULL) - {1'b0, duty_d};

  // Multiplier operand A.
  always_comb begin
    unique case (cw.a_sel)
      A_MZ:     a_op = {{(A_W - VAL_W){mz[VAL_W-1]}}, mz};
      A_DUTY:   a_op = A_W'(duty_q);
      A_ERR:    a_op = {{(A_W - VAL_W){err_q[VAL_W-1]}}, err_q};
      A_ERRP:   a_op = {{(A_W - VAL_W){errp_q[VAL_W-1]}}, errp_q};
      A_X:      a_op = A_W'(x_q);
      A_SAMPLE: a_op = A_W'(s_sat);
      A_REST:   a_op = A_W'(rest);
      A_TSM:    a_op = A_W'(ts_q);
    endcase
  end

  // Multiplier operand B.
  always_comb begin
    unique case (cw.b_sel)
      B_MEAS:  b_op = B_W'(K_MEAS);
      B_DUTY:  b_op = B_W'(K_DUTY);
      B_ERR:   b_op = B_W'(K_ERR);
      B_ERRA:  b_op = B_W'(K_ERRA);
      B_RCP10: b_op = B_W'(RCP10);
      B_RCP7:  b_op = B_W'(RCP7);
      B_SCALE: b_op = B_W'(TEMP_SPAN);
      B_NINE:  b_op = B_W'(FILT_OLD_WT);
      B_WIN:   b_op = B_W'(win_q);
      default: b_op = '0;
    endcase
  end

  // Shared multiplier and accumulator.
  assign p_d   = a_op * b_op;
  assign p_ext = {{(ACC_W - P_W){p_q[P_W-1]}}, p_q};

  always_comb begin
    unique case (cw.acc_op)
      ACC_HOLD:     acc_d = acc_q;
      ACC_LOAD:     acc_d = p_ext;
      ACC_LOAD_SH7: acc_d = p_ext <<< MEAS_SH;
      ACC_ADD:      acc_d = acc_q + p_ext;
      ACC_SUB:      acc_d = acc_q - p_ext;
      default:      acc_d = acc_q;
    endcase
  end

  // Rounding of the accumulator for the writeback operations (half up).
  assign est_sum  = acc_q + (ACC_W'(1) << (EST_SH - 1));
  assign pi_sum   = acc_q + (ACC_W'(1) << (PI_SH - 1));
  assign fire_sum = acc_q + (ACC_W'(1) << (FIRE_SH - 1));
  assign pi_rnd   = pi_sum[PI_SH +: SAT_W];
  assign dsum     = $signed({(SAT_W - DUTY_W)'(0), duty_q}) + pi_rnd;
  assign err_diff = sz - {{(SZ_W - VAL_W){est_q[VAL_W-1]}}, est_q};
  assign x_full   = (SAT_W'(sz) << START_SH) + SAT_W'(START_BIAS);
  assign crossing = (sample_q < zthr_q) && !latch_q;

  // Writeback of the current control word into state.
  always_comb begin
    duty_d   = duty_q;
    err_d    = err_q;
    errp_d   = errp_q;
    est_d    = est_q;
    ts_d     = ts_q;
    amb_d    = amb_q;
    latch_d  = latch_q;
    reseed_d = reseed_q;
    x_d      = x_q;
    arm_d    = 1'b0;
    now_d    = 1'b0;
    delay_d  = '0;
    if (exec) begin
      unique case (cw.wb)
        WB_NONE: ;
        WB_T: x_d = X_W'(acc_q[ADC_BITS +: TEMP_W]);
        WB_SEED: begin
          ts_d     = x_q[TEMP_W-1:0];
          reseed_d = 1'b0;
        end
        WB_FILT_X: x_d = acc_q[X_W-1:0] + x_q + X_W'(FILT_BIAS);
        WB_FILT: ts_d = acc_q[RCP10_SH +: TEMP_W];
        WB_EST: begin
          est_d  = sat_val({{(SAT_W - (ACC_W - EST_SH)){est_sum[ACC_W-1]}},
                            est_sum[ACC_W-1:EST_SH]});
          errp_d = err_q;
        end
        WB_ERR: err_d = sat_val({{(SAT_W - SZ_W){err_diff[SZ_W-1]}}, err_diff});
        WB_DUTY_PI: begin
          if (dsum[SAT_W-1]) begin
            duty_d = '0;
          end else if (dsum > $signed(SAT_W'(DUTY_FULL))) begin
            duty_d = DUTY_W'(DUTY_FULL);
          end else begin
            duty_d = dsum[DUTY_W-1:0];
          end
          reseed_d = 1'b1;
        end
        WB_AMB: amb_d = ts_q;
        WB_START_X: begin
          // A non-positive gap gives zero duty; a large one is capped at full duty.
          if (sz[SZ_W-1] || (sz == '0)) begin
            x_d = '0;
          end else if (x_full > SAT_W'(START_X_MAX)) begin
            x_d = X_W'(START_X_MAX);
          end else begin
            x_d = x_full[X_W-1:0];
          end
        end
        WB_DUTY_DIV: duty_d = acc_q[RCP7_SH +: DUTY_W];
        WB_MAINS: begin
          // Crossing with hysteresis; zero duty latches without firing.
          if (crossing) begin
            latch_d = 1'b1;
            if (duty_q >= DUTY_W'(DUTY_FULL)) begin
              now_d = 1'b1;
            end else if (duty_q != '0) begin
              arm_d   = 1'b1;
              delay_d = fire_sum[FIRE_SH +: DELAY_W];
            end
          end else if (sample_q > rthr_q) begin
            latch_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Control, configuration and regulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      sp_q        <= RST_SETPOINT;
      zthr_q      <= RST_ZERO_THR;
      rthr_q      <= RST_REARM;
      win_q       <= RST_WINDOW;
      duty_q      <= '0;
      err_q       <= '0;
      errp_q      <= '0;
      est_q       <= '0;
      ts_q        <= '0;
      amb_q       <= '0;
      latch_q     <= 1'b0;
      reseed_q    <= 1'b1;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        step_q <= entry_step(op_e'(s_axis_tuser[OP_W-1:0]));
      end else if (exec) begin
        if (cw.emit) begin
          busy_q <= 1'b0;
        end else if ((cw.jmp == JMP_RESEED) && reseed_q) begin
          step_q <= cw.target;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (exec && cw.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (reg_idx_e'(paddr[3:2]))
          REG_SETPOINT:  sp_q   <= pwdata[SP_W-1:0];
          REG_ZERO_THR:  zthr_q <= pwdata[THR_W-1:0];
          REG_REARM_THR: rthr_q <= pwdata[THR_W-1:0];
          REG_FIRE_WIN:  win_q  <= pwdata[WIN_W-1:0];
        endcase
      end
      duty_q   <= duty_d;
      err_q    <= err_d;
      errp_q   <= errp_d;
      est_q    <= est_d;
      ts_q     <= ts_d;
      amb_q    <= amb_d;
      latch_q  <= latch_d;
      reseed_q <= reseed_d;
    end
  end

  // Captured item, datapath registers and the result register.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= s_axis_tdata[SAMPLE_W-1:0];
    end
    if (exec) begin
      p_q   <= p_d;
      acc_q <= acc_d;
      x_q   <= x_d;
    end
    if (exec && cw.emit) begin
      o_arm_q   <= arm_d;
      o_now_q   <= now_d;
      o_delay_q <= delay_d;
      o_plong_q <= (rest_d < (DUTY_W + 1)'(PULSE_REST_LIM));
      o_duty_q  <= duty_d;
      o_ts_q    <= ts_d;
      o_est_q   <= est_d;
      o_err_q   <= err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {o_err_q, o_est_q, o_ts_q, o_duty_q, o_plong_q,
                          o_delay_q, o_now_q, o_arm_q};

`ifndef SYNTH
  // Duty never leaves the range 0..full.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_W'(DUTY_FULL))
    else $error("duty above full scale");

  // A result step that finds the result register occupied waits in place.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cw.emit && !out_free |=> busy_q && $stable(step_q))
    else $error("sequencer moved while the result register was full");

  // A result step that goes through ends the program and presents the result.
  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cw.emit && out_free |=> !busy_q && m_axis_tvalid)
    else $error("result step did not complete the item");

  // The PI update always arms filter reseeding.
  a_tick_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (cw.wb == WB_DUTY_PI) |=> reseed_q)
    else $error("control tick did not request a filter reseed");
`endif

endmodule

// ===== sim/heater_pi_phase_angle_controller_checker.sv =====
// Scoreboard for the heater regulator: predicts each result item and checks the block against it.
module heater_pi_phase_angle_controller_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [hppac_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [9:0] sample
  input  logic [hppac_pkg::IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] op
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] fire_arm, [1] fire_now, [15:2] fire_delay_us, [16] pulse_long, [32:17] duty_out,
  // [47:33] filtered_temp, [63:48] estimated_temp, [79:64] control_error
  input  logic [hppac_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hppac_pkg::ADDR_W-1:0]      paddr,
  input  logic [hppac_pkg::DATA_W-1:0]      pwdata,
  input  logic [hppac_pkg::DATA_W-1:0]      prdata,
  input  logic                              pready,
  output int                                fail_count,
  output int                                pending,
  output int                                results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import hppac_pkg::*;

  // Regulator gains and scales, Q16 gains, Q8.8 temperatures, Q1.15 duty.
  localparam longint FULL_DUTY     = 32768;
  localparam longint ADC_SPAN      = 28160;
  localparam longint GAIN_MEAS     = 63000;
  localparam longint GAIN_DUTY     = 72286;
  localparam longint GAIN_ERR      = 9372;
  localparam longint GAIN_ERR_PREV = 9005;

  // One result item, laid out as on the output bus (lowest field last).
  typedef struct packed {
    logic signed [VAL_W-1:0] ctrl_err;
    logic signed [VAL_W-1:0] estimate;
    logic [TEMP_W-1:0]       temp;
    logic [DUTY_W-1:0]       duty;
    logic                    pulse_long;
    logic [DELAY_W-1:0]      delay;
    logic                    fire_now;
    logic                    fire_arm;
  } heater_result_t;

  typedef struct {
    heater_result_t res;
    op_e            op;
    int unsigned    seq;
  } awaited_t;

  // Register copies.
  logic [SP_W-1:0]  setpoint_cfg;
  logic [THR_W-1:0] zero_thr_cfg;
  logic [THR_W-1:0] rearm_thr_cfg;
  logic [WIN_W-1:0] window_cfg;

  // Regulator state.
  longint duty_q;
  longint err_now_q;
  longint err_prev_q;
  longint temp_sm_q;
  longint ambient_q;
  longint estimate_q;
  bit     latched_q;
  bit     reseed_q;

  awaited_t    awaited_q[$];
  int          fail_total = 0;
  int          results_n = 0;
  int unsigned items_n = 0;

  assign fail_count      = fail_total;
  assign results_checked = results_n;

  function automatic void reset_model();
    setpoint_cfg  = SP_W'(30);
    zero_thr_cfg  = THR_W'(2);
    rearm_thr_cfg = THR_W'(10);
    window_cfg    = WIN_W'(7333);
    duty_q        = 0;
    err_now_q     = 0;
    err_prev_q    = 0;
    temp_sm_q     = 0;
    ambient_q     = 0;
    estimate_q    = 0;
    latched_q     = 1'b0;
    reseed_q      = 1'b1;
  endfunction

  // Round half up, then drop the low bits.
  function automatic longint round_drop(input longint x, input int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Advance the regulator by one input item and return the result it produces.
  function automatic heater_result_t regulate_item(input op_e op, input logic [SAMPLE_W-1:0] smp);
    heater_result_t r;
    longint t;
    longint mz;
    longint sz;
    longint acc;
    longint d;
    r = '0;
    unique case (op)
      OP_MAINS: begin
        if (smp < zero_thr_cfg && !latched_q) begin
          latched_q = 1'b1;
          if (duty_q >= FULL_DUTY) begin
            r.fire_now = 1'b1;
          end else if (duty_q > 0) begin
            r.fire_arm = 1'b1;
            acc = (FULL_DUTY - duty_q) * longint'(window_cfg);
            r.delay = DELAY_W'((acc + FULL_DUTY / 2) >> 15);
          end
        end else if (smp > rearm_thr_cfg) begin
          latched_q = 1'b0;
        end
      end
      OP_TEMP: begin
        t = (longint'(smp) * ADC_SPAN) >> ADC_BITS;
        if (reseed_q) begin
          temp_sm_q = t;
          reseed_q  = 1'b0;
        end else begin
          temp_sm_q = (9 * temp_sm_q + t + 5) / 10;
        end
      end
      OP_TICK: begin
        mz         = temp_sm_q - ambient_q;
        sz         = longint'(setpoint_cfg) * 256 - ambient_q;
        err_prev_q = err_now_q;
        acc        = mz * GAIN_MEAS * 128 + duty_q * GAIN_DUTY;
        estimate_q = clip16(round_drop(acc, 23));
        err_now_q  = clip16(sz - estimate_q);
        acc        = err_now_q * GAIN_ERR - err_prev_q * GAIN_ERR_PREV;
        d          = duty_q + round_drop(acc, 9);
        if (d < 0) begin
          d = 0;
        end
        if (d > FULL_DUTY) begin
          d = FULL_DUTY;
        end
        duty_q   = d;
        reseed_q = 1'b1;
      end
      default: begin
        // Start: the current reading becomes ambient and the duty is preset.
        ambient_q = temp_sm_q;
        d = longint'(setpoint_cfg) * 256 - ambient_q;
        if (d <= 0) begin
          duty_q = 0;
        end else begin
          d = (d * 32 + 3) / 7;
          duty_q = (d > FULL_DUTY) ? FULL_DUTY : d;
        end
      end
    endcase
    r.pulse_long = ((FULL_DUTY - duty_q) * 10 < FULL_DUTY);
    r.duty       = DUTY_W'(duty_q);
    r.temp       = TEMP_W'(temp_sm_q);
    r.estimate   = VAL_W'(estimate_q);
    r.ctrl_err   = VAL_W'(err_now_q);
    return r;
  endfunction

  function automatic void report_failure(input string what);
    fail_total++;
    $display("%0t ns: %s", $time, what);
  endfunction

  function automatic void check_field(input string field, input int unsigned seq,
                                      input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      report_failure($sformatf("item %0d %s: expected %0d, got %0d", seq, field, exp_v, got_v));
    end
  endfunction

  function automatic void compare_result(input awaited_t w, input heater_result_t got);
    check_field("fire_arm", w.seq, w.res.fire_arm, got.fire_arm);
    check_field("fire_now", w.seq, w.res.fire_now, got.fire_now);
    check_field("fire_delay_us", w.seq, w.res.delay, got.delay);
    check_field("pulse_long", w.seq, w.res.pulse_long, got.pulse_long);
    check_field("duty_out", w.seq, w.res.duty, got.duty);
    check_field("filtered_temp", w.seq, w.res.temp, got.temp);
    check_field("estimated_temp", w.seq, w.res.estimate, got.estimate);
    check_field("control_error", w.seq, w.res.ctrl_err, got.ctrl_err);
  endfunction

  function automatic logic [DATA_W-1:0] setting_value(input reg_idx_e idx);
    unique case (idx)
      REG_SETPOINT:  return DATA_W'(setpoint_cfg);
      REG_ZERO_THR:  return DATA_W'(zero_thr_cfg);
      REG_REARM_THR: return DATA_W'(rearm_thr_cfg);
      default:       return DATA_W'(window_cfg);
    endcase
  endfunction

  // Watch both streams and the register port at every rising edge.
  always @(posedge clk_i) begin : watch
    awaited_t       fresh;
    awaited_t       head;
    heater_result_t got;
    reg_idx_e       idx;
    if (!rst_ni) begin
      reset_model();
      awaited_q.delete();
    end else begin
      // Results leave before new items enter, so the oldest expectation is matched.
      if (m_axis_tvalid && m_axis_tready) begin
        got = heater_result_t'(m_axis_tdata);
        if (awaited_q.size() == 0) begin
          report_failure($sformatf("unexpected result item %h", m_axis_tdata));
        end else begin
          head = awaited_q.pop_front();
          compare_result(head, got);
          results_n++;
        end
      end
      // Register writes update the predictor; reads must return the stored value.
      if (psel && penable && pready) begin
        idx = reg_idx_e'(paddr[3:2]);
        if (pwrite) begin
          unique case (idx)
            REG_SETPOINT:  setpoint_cfg  = pwdata[SP_W-1:0];
            REG_ZERO_THR:  zero_thr_cfg  = pwdata[THR_W-1:0];
            REG_REARM_THR: rearm_thr_cfg = pwdata[THR_W-1:0];
            default:       window_cfg    = pwdata[WIN_W-1:0];
          endcase
        end else if (prdata !== setting_value(idx)) begin
          report_failure($sformatf("register %s read: expected %0d, got %0d",
                                   idx.name(), setting_value(idx), prdata));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fresh.op  = op_e'(s_axis_tuser);
        fresh.seq = items_n;
        fresh.res = regulate_item(fresh.op, s_axis_tdata[SAMPLE_W-1:0]);
        items_n++;
        awaited_q.push_back(fresh);
      end
    end
    pending <= awaited_q.size();
  end

endmodule

// ===== sim/tb_heater_pi_phase_angle_controller.sv =====
// Testbench top for the heater regulator: clock, reset, stimulus, stalls and the verdict.
module tb_heater_pi_phase_angle_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import hppac_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int TIMEOUT_NS   = 12_000_000;
  localparam int PHASE_ITEMS  = 170;
  localparam int SETTLE_TAIL  = 12;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  int fail_count;
  int pending;
  int results_checked;

  bit bursty = 1'b1;
  int item_total = 0;
  int op_tally[4] = '{default: 0};
  int settings_applied = 0;
  int setpoint_now = 30;
  int temp_level;

  heater_pi_phase_angle_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  heater_pi_phase_angle_controller_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_tvalid),
    .s_axis_tready   (s_tready),
    .s_axis_tdata    (s_tdata),
    .s_axis_tuser    (s_tuser),
    .m_axis_tvalid   (m_tvalid),
    .m_axis_tready   (m_tready),
    .m_axis_tdata    (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!bursty || r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  function automatic int adc_clip(input int v);
    if (v < 0) begin
      return 0;
    end
    return (v > 1023) ? 1023 : v;
  endfunction

  // Present one item and hold it until the block takes it.
  task automatic send_item(input op_e op, input int smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, smp[SAMPLE_W-1:0]};
    s_tuser  <= op;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    item_total++;
    op_tally[int'(op)]++;
  endtask

  // One register access with its setup and access cycles.
  task automatic apb_access(input bit is_write, input reg_idx_e idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_all_settings();
    for (int k = 0; k < 4; k++) begin
      apb_access(1'b0, reg_idx_e'(k), '0);
    end
  endtask

  // Wait until every result has been taken and the block has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_TAIL) @(posedge clk_i);
  endtask

  // Write all four registers with noise above the used bits, then read them back.
  task automatic apply_settings(input int sp, input int zthr, input int rearm, input int win);
    settle();
    apb_access(1'b1, REG_SETPOINT, ($urandom() & ~32'h7F) | sp);
    apb_access(1'b1, REG_ZERO_THR, ($urandom() & ~32'h3FF) | zthr);
    apb_access(1'b1, REG_REARM_THR, ($urandom() & ~32'h3FF) | rearm);
    apb_access(1'b1, REG_FIRE_WIN, ($urandom() & ~32'h3FFF) | win);
    read_all_settings();
    setpoint_now = sp & 32'h7F;
    settings_applied++;
  endtask

  // A mains half cycle: falling to zero, a few low readings, rising again.
  task automatic mains_half_wave();
    int amp;
    int steps;
    amp = ($urandom_range(0, 99) < 80) ? $urandom_range(300, 1023) : $urandom_range(0, 1023);
    steps = $urandom_range(2, 6);
    for (int i = steps; i >= 0; i--) begin
      send_item(OP_MAINS, amp * i / steps);
    end
    repeat ($urandom_range(0, 2)) send_item(OP_MAINS, $urandom_range(0, 20));
    for (int i = 1; i <= steps; i++) begin
      send_item(OP_MAINS, amp * i / steps);
    end
  endtask

  // Mostly regulation cycles (readings, tick, half wave); the rest is noise and odd orders.
  task automatic run_random_phase(input int budget);
    int first;
    int r;
    first = item_total;
    temp_level = adc_clip(setpoint_now * 1024 / 110 + $urandom_range(0, 160) - 80);
    repeat ($urandom_range(1, 3)) send_item(OP_TEMP, adc_clip(temp_level + $urandom_range(0, 24) - 12));
    send_item(OP_START, $urandom_range(0, 1023));
    while (item_total - first < budget) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(OP_TEMP, adc_clip(temp_level + $urandom_range(0, 24) - 12));
        end
        send_item(OP_TICK, $urandom_range(0, 1023));
        mains_half_wave();
        temp_level = adc_clip(temp_level + $urandom_range(0, 40) - 20);
      end else if (r < 68) begin
        mains_half_wave();
        mains_half_wave();
      end else if (r < 76) begin
        if ($urandom_range(0, 9) < 3) begin
          temp_level = $urandom_range(0, 1023);
        end
        send_item(OP_TEMP, temp_level);
        send_item(OP_START, $urandom_range(0, 1023));
      end else if (r < 92) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(op_e'($urandom_range(0, 3)), $urandom_range(0, 1023));
        end
      end else if (r < 96) begin
        // Ticks with no fresh reading in between.
        repeat ($urandom_range(2, 5)) send_item(OP_TICK, $urandom_range(0, 1023));
      end else begin
        // Mains stuck low: the latch must hold.
        repeat ($urandom_range(2, 5)) send_item(OP_MAINS, $urandom_range(0, 3));
      end
    end
  endtask

  // Output side: random stalls while bursty, otherwise always ready.
  initial begin
    int hold;
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Main sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_all_settings();

    // Directed part on the reset settings.
    send_item(OP_START, 0);      // no reading yet: ambient is zero, duty goes full
    send_item(OP_MAINS, 0);      // crossing at full duty fires at once
    send_item(OP_MAINS, 1);      // still latched
    send_item(OP_MAINS, 6);      // between thresholds: latch held
    send_item(OP_MAINS, 1023);   // re-arm
    send_item(OP_TEMP, 1023);    // seeds the filter
    send_item(OP_TEMP, 0);
    send_item(OP_TEMP, 1023);
    send_item(OP_TICK, 1023);
    send_item(OP_TEMP, 300);     // first reading after a tick seeds again
    send_item(OP_TICK, 0);
    send_item(OP_MAINS, 0);
    send_item(OP_MAINS, 1023);
    send_item(OP_TEMP, 1023);
    send_item(OP_START, 512);    // hot ambient: duty drops to zero
    send_item(OP_MAINS, 0);      // crossing at zero duty latches without firing
    send_item(OP_MAINS, 0);
    send_item(OP_MAINS, 11);
    send_item(OP_TICK, 5);
    send_item(OP_TICK, 1000);
    send_item(OP_TEMP, 0);
    send_item(OP_START, 0);
    send_item(OP_MAINS, 0);
    send_item(OP_MAINS, 1023);

    // Random phases over several register settings, extremes included.
    apply_settings(30, 2, 10, 7333);
    run_random_phase(PHASE_ITEMS);
    apply_settings(0, 0, 0, 0);
    run_random_phase(PHASE_ITEMS);
    apply_settings(99, 1023, 1023, 8333);
    run_random_phase(PHASE_ITEMS);
    apply_settings(127, 512, 600, 16383);
    run_random_phase(PHASE_ITEMS);
    apply_settings(50, 100, 50, 4000);
    run_random_phase(PHASE_ITEMS);
    bursty = 1'b0;
    apply_settings($urandom_range(20, 80), $urandom_range(1, 60), $urandom_range(60, 300),
                   $urandom_range(0, 8333));
    run_random_phase(PHASE_ITEMS);
    settle();

    $display("Sent %0d items: %0d mains, %0d temperature, %0d control ticks, %0d starts.",
             item_total, op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
    $display("Compared %0d results over %0d register settings plus the reset values.",
             results_checked, settings_applied);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding.", pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
design/hppac_pkg.sv
design/heater_pi_phase_angle_controller.sv
sim/heater_pi_phase_angle_controller_checker.sv
sim/tb_heater_pi_phase_angle_controller.sv
